// ----- hdl/efd_pkg.sv -----
// Shared types and constants for the escaped frame deframer.
// Depends on nothing; used by the parser, the emitter and the top level.
package efd_pkg;

  localparam logic [7:0] RESET_CODE  = 8'h23;
  localparam logic [7:0] ESCAPE_CODE = 8'h42;
  localparam logic [7:0] ESCAPE_XOR  = 8'h55;
  localparam logic [7:0] CHANNEL_COUNT_RESET = 8'd8;

  // Hand-off of a complete, accepted frame from the parser to the emitter.
  typedef struct packed {
    logic       go;
    logic [7:0] channel;
    logic [7:0] length;
  } frame_start_t;

endpackage

// ----- hdl/efd_store.sv -----
// Payload store: one write port, one read port with registered read data.
// Depends on nothing.
module efd_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds its value until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/efd_parser.sv -----
// Byte-stuffing parser: escape and reset handling, length/channel/payload
// phases, store writes and the frame start request. Uses efd_pkg.
module efd_parser import efd_pkg::*; #(
  parameter int STORE_BYTES = 32,
  parameter int AW          = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_data,
  output logic          store_we,
  output logic [AW-1:0] store_addr,
  output logic [7:0]    store_data,
  output frame_start_t  start
);

  typedef enum logic [1:0] {
    PH_LENGTH,
    PH_CHANNEL,
    PH_PAYLOAD
  } phase_t;

  localparam logic [8:0] STORE_LIMIT = 9'(STORE_BYTES);

  phase_t     phase;
  logic       escape_pending;
  logic [7:0] packet_length;
  logic [7:0] packet_channel;
  logic [7:0] byte_count;
  logic [7:0] channel_count;

  logic [7:0] decoded;
  logic       is_data;
  logic [7:0] count_next;
  logic       frame_done;
  logic       fits;

  always_comb begin
    decoded    = escape_pending ? (rx_byte ^ ESCAPE_XOR) : rx_byte;
    is_data    = escape_pending || (rx_byte != RESET_CODE && rx_byte != ESCAPE_CODE);
    count_next = byte_count + 8'd1;
    frame_done = count_next >= packet_length;
    fits       = {1'b0, byte_count} < STORE_LIMIT;
    store_we   = accept && is_data && (phase == PH_PAYLOAD) && fits;
    store_addr = byte_count[AW-1:0];
    store_data = decoded;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LENGTH;
      escape_pending <= 1'b0;
      packet_length  <= 8'd0;
      packet_channel <= 8'd0;
      byte_count     <= 8'd0;
      channel_count  <= CHANNEL_COUNT_RESET;
      start          <= '0;
    end else begin
      start.go <= 1'b0;
      if (cfg_we) begin
        channel_count <= cfg_data;
      end
      if (accept) begin
        if (escape_pending) begin
          escape_pending <= 1'b0;
        end else if (rx_byte == RESET_CODE) begin
          phase      <= PH_LENGTH;
          byte_count <= 8'd0;
        end else if (rx_byte == ESCAPE_CODE) begin
          escape_pending <= 1'b1;
        end
        if (is_data) begin
          unique case (phase)
            PH_CHANNEL: begin
              packet_channel <= decoded;
              byte_count     <= 8'd0;
              phase          <= PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
              if (frame_done) begin
                phase      <= PH_LENGTH;
                byte_count <= 8'd0;
                // Oversized frames and unknown channels are dropped here.
                if ({1'b0, packet_length} <= STORE_LIMIT &&
                    packet_channel < channel_count) begin
                  start.go      <= 1'b1;
                  start.channel <= packet_channel;
                  start.length  <= packet_length;
                end
              end else begin
                byte_count <= count_next;
              end
            end
            default: begin
              if (decoded != 8'd0) begin
                packet_length <= decoded;
                phase         <= PH_CHANNEL;
              end else begin
                phase <= PH_LENGTH;
              end
            end
          endcase
        end
      end
    end
  end

endmodule

// ----- hdl/efd_emitter.sv -----
// Frame emitter: reads a stored frame byte by byte and drives the output
// register with its fields. Uses efd_pkg; reads through efd_store.
module efd_emitter import efd_pkg::*; #(
  parameter int AW          = 5,
  parameter int CW          = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  frame_start_t  start,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  input  logic [7:0]    rd_data,
  output logic          busy,
  output logic          tx_valid,
  input  logic          tx_stall,
  output logic [7:0]    channel_id,
  output logic [5:0]    frame_length,
  output logic [4:0]    byte_index,
  output logic [7:0]    payload_byte,
  output logic          last_byte
);

  logic          active;
  logic [7:0]    length;
  logic [7:0]    channel;
  logic [CW-1:0] rd_idx;
  logic          pending;
  logic [AW-1:0] pend_idx;
  logic [AW-1:0] out_idx;
  logic [7:0]    out_data;

  logic rd_more;
  logic load;

  always_comb begin
    rd_more = 8'(rd_idx) < length;
    // The read data register holds one byte that waits for the output register.
    load    = pending && (!tx_valid || !tx_stall);
    rd_en   = active && rd_more && (!pending || load);
    rd_addr = rd_idx[AW-1:0];
    busy    = active || pending || tx_valid;

    channel_id   = channel;
    frame_length = length[5:0];
    byte_index   = 5'(out_idx);
    payload_byte = out_data;
    last_byte    = (8'(out_idx) + 8'd1) == length;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      pending  <= 1'b0;
      tx_valid <= 1'b0;
      rd_idx   <= '0;
      length   <= 8'd0;
    end else begin
      if (start.go) begin
        active  <= 1'b1;
        rd_idx  <= '0;
        length  <= start.length;
        channel <= start.channel;
      end else if (rd_en) begin
        rd_idx   <= rd_idx + CW'(1);
        pend_idx <= rd_idx[AW-1:0];
        if (8'(rd_idx) + 8'd1 == length) begin
          active <= 1'b0;
        end
      end
      if (rd_en) begin
        pending <= 1'b1;
      end else if (load) begin
        pending <= 1'b0;
      end
      if (load) begin
        tx_valid <= 1'b1;
        out_data <= rd_data;
        out_idx  <= pend_idx;
      end else if (!tx_stall) begin
        tx_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/escaped_frame_deframer_unit.sv -----
// Top level of the escaped frame deframer: parser, payload store, emitter.
// Depends on efd_pkg, efd_parser, efd_store and efd_emitter.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------------------
//   rx       | in        | rx_valid/rx_stall  | rx_byte
//   tx       | out       | tx_valid/tx_stall  | channel_id, frame_length, byte_index,
//            |           |                    | payload_byte, last_byte
//   cfg      | in        | cfg_we             | cfg_data (channel_count)
//
// A received byte that completes no deliverable frame does not raise rx_stall.
// A delivered frame holds rx_stall high from its start request until the
// output register is empty again, longer under tx_stall; the single read port
// of the store gives one byte per cycle into the output register while tx_stall is low.
// rst is synchronous; no clearing pass is needed since a frame only reads
// bytes it wrote. channel_count resets to 8.
module escaped_frame_deframer_unit import efd_pkg::*; #(
  parameter int STORE_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  output logic       tx_valid,
  input  logic       tx_stall,
  output logic [7:0] channel_id,
  output logic [5:0] frame_length,
  output logic [4:0] byte_index,
  output logic [7:0] payload_byte,
  output logic       last_byte
);

  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int CW = $clog2(STORE_BYTES + 1);

  logic          accept;
  logic          busy;
  logic          store_we;
  logic [AW-1:0] store_addr;
  logic [7:0]    store_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  frame_start_t  start;

  assign rx_stall = busy || start.go;
  assign accept   = rx_valid && !rx_stall;

  efd_parser #(
    .STORE_BYTES(STORE_BYTES),
    .AW(AW)
  ) u_parser (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .rx_byte(rx_byte),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .store_we(store_we),
    .store_addr(store_addr),
    .store_data(store_data),
    .start(start)
  );

  efd_store #(
    .DEPTH(STORE_BYTES),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .we(store_we),
    .waddr(store_addr),
    .wdata(store_data),
    .re(rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  efd_emitter #(
    .AW(AW),
    .CW(CW)
  ) u_emitter (
    .clk(clk),
    .rst(rst),
    .start(start),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .busy(busy),
    .tx_valid(tx_valid),
    .tx_stall(tx_stall),
    .channel_id(channel_id),
    .frame_length(frame_length),
    .byte_index(byte_index),
    .payload_byte(payload_byte),
    .last_byte(last_byte)
  );

`ifndef SYNTHESIS
  // A frame start is never raised while the emitter still owns the store.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    !(start.go && busy))
    else $error("frame start while emitter busy");

  // The store is never written while a frame is being read out.
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    !(store_we && busy))
    else $error("store write during read-out");

  // The byte marked last sits at the end of the frame.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && last_byte) |-> (5'(frame_length - 6'd1) == byte_index))
    else $error("last byte at wrong index");
`endif

endmodule
